FILE: sv/mdb_pkg.sv
// ============================================================================
// mdb_pkg
// shared types, constants and helpers of the mic decimator, dc blocker and
// peak meter
// ============================================================================
package mdb_pkg;

   // limits of the configuration
   localparam int MAX_OVERSAMPLE    = 4;
   localparam int MAX_FRAME_SAMPLES = 1024;
   localparam int MAX_GAIN_SHIFT    = 16;

   // field widths
   localparam int WORD_W   = 32;                 // slot word
   localparam int OVS_W    = 3;
   localparam int GAIN_W   = 5;
   localparam int POLE_W   = 15;
   localparam int SPF_W    = 11;
   localparam int PCM_W    = 16;
   localparam int LEVEL_W  = 7;
   localparam int CLIPS_W  = 32;
   localparam int POS_W    = 10;                 // frame position, below the max length
   localparam int PEAK_W   = 16;

   // datapath widths
   localparam int SUM_W    = WORD_W + 3;         // group sum, leftover words included
   localparam int MAG_W    = SUM_W - 1;          // magnitude of the group sum
   localparam int FRAC_W   = 16;                 // fraction bits of the blocker
   localparam int X_W      = SUM_W + FRAC_W;     // scaled blocker input
   localparam int Y_W      = 52;                 // blocker output
   localparam int D_W      = X_W + 1;            // input difference
   localparam int LO_W     = 26;                 // low part of the feedback multiply
   localparam int HI_W     = Y_W - LO_W;
   localparam int PLO_W    = LO_W + POLE_W;
   localparam int PHI_W    = HI_W + POLE_W + 1;
   localparam int P_W      = PHI_W + LO_W;
   localparam int POLE_FRAC = 15;

   // divider
   localparam int DIV_BITS  = 8;                 // quotient bits per cycle
   localparam int DIV_STEPS = (MAG_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_W     = DIV_STEPS * DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // meter
   localparam int PCT_SCALE     = 100;
   localparam int FULL_SCALE    = 32767;
   localparam int FULL_SHIFT    = 15;
   localparam int LEVEL_RELEASE = 2;
   localparam int PCT_PROD_W    = PEAK_W + LEVEL_W;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIC_SLOT          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERSAMPLE        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_SHIFT        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DC_POLE           = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_FRAME = 3'd4;

   typedef struct packed {
      logic                mic_slot;
      logic [OVS_W-1:0]    oversample;
      logic [GAIN_W-1:0]   gain_shift;
      logic [POLE_W-1:0]   dc_pole;
      logic [SPF_W-1:0]    samples_per_frame;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mic_slot:          1'b0,
      oversample:        3'd4,
      gain_shift:        5'd0,
      dc_pole:           15'd32604,
      samples_per_frame: 11'd320
   };

   typedef enum logic [1:0] {
      CMD_SAMPLE,
      CMD_RESTART,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      clear_clips;
      logic signed [SUM_W-1:0]   sum;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_HI,
      ST_DIV_WAIT,
      ST_SUM,
      ST_SAT,
      ST_PCM,
      ST_METER
   } back_state_type;

   function automatic logic [OVS_W-1:0] clamp_oversample(input logic [OVS_W-1:0] v);
      logic [OVS_W-1:0] r;
      r = v;
      if (v == '0) r = OVS_W'(1);
      else if (v > OVS_W'(MAX_OVERSAMPLE)) r = OVS_W'(MAX_OVERSAMPLE);
      return r;
   endfunction

   function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
      logic [GAIN_W-1:0] r;
      r = v;
      if (v > GAIN_W'(MAX_GAIN_SHIFT)) r = GAIN_W'(MAX_GAIN_SHIFT);
      return r;
   endfunction

   function automatic logic [SPF_W-1:0] clamp_frame(input logic [SPF_W-1:0] v);
      logic [SPF_W-1:0] r;
      r = v;
      if (v == '0) r = SPF_W'(1);
      else if (v > SPF_W'(MAX_FRAME_SAMPLES)) r = SPF_W'(MAX_FRAME_SAMPLES);
      return r;
   endfunction

endpackage

FILE: sv/mdb_div.sv
// ============================================================================
// mdb_div
// unsigned divide of a group-sum magnitude by the oversample count,
// eight quotient bits per cycle, shift only for powers of two
// ============================================================================
module mdb_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mdb_pkg::MAG_W-1:0]   dividend,
   input  logic [mdb_pkg::OVS_W-1:0]   divisor,
   output logic                        busy,
   output logic [mdb_pkg::MAG_W-1:0]   quotient
);
   import mdb_pkg::*;

   logic [DIV_W-1:0]     work_ff, work_in;
   logic [1:0]           rem_ff, rem_in;
   logic [OVS_W-1:0]     divisor_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 pow2;
   logic [1:0]           pow2_shift;

   assign pow2       = (divisor & (divisor - OVS_W'(1))) == '0;
   assign pow2_shift = divisor[2] ? 2'd2 : (divisor[1] ? 2'd1 : 2'd0);

   // restoring steps, remainder stays below the divisor
   always_comb begin : div_step
      logic [OVS_W-1:0] t;
      work_in = work_ff;
      rem_in  = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         t       = {rem_in, work_in[DIV_W-1]};
         work_in = {work_in[DIV_W-2:0], 1'b0};
         if (t >= divisor_ff) begin
            t          = t - divisor_ff;
            work_in[0] = 1'b1;
         end
         rem_in = t[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= pow2 ? '0 : DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         divisor_ff <= divisor;
         rem_ff     <= '0;
         if (pow2) begin
            work_ff <= DIV_W'(dividend >> pow2_shift);
         end else begin
            work_ff <= DIV_W'(dividend);
         end
      end else if (cnt_ff != '0) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = work_ff[MAG_W-1:0];

endmodule

FILE: sv/mdb_front.sv
// ============================================================================
// mdb_front
// accepts frames, picks the mic slot, sums decimation groups and queues
// commands for the back end
// ============================================================================
module mdb_front (
   input  logic                           clock,
   input  logic                           reset,
   input  mdb_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [mdb_pkg::WORD_W-1:0] req_slot0_word,
   input  logic signed [mdb_pkg::WORD_W-1:0] req_slot1_word,
   input  logic                           req_restart,
   input  logic                           req_clear_clips,
   input  mdb_pkg::q_status_type          q_status,
   output logic                           q_push,
   output mdb_pkg::cmd_type               q_entry
);
   import mdb_pkg::*;

   logic [1:0]              decim_count_ff;
   logic signed [SUM_W-1:0] decim_sum_ff;
   logic signed [WORD_W-1:0] word;
   logic signed [SUM_W-1:0] sum_next;
   logic [OVS_W-1:0]        count_next;
   logic                    group_done;
   logic                    accept;

   assign req_ready  = !q_status.full;
   assign accept     = req_valid && req_ready;
   assign word       = cfg.mic_slot ? req_slot1_word : req_slot0_word;
   assign sum_next   = decim_sum_ff + {{(SUM_W-WORD_W){word[WORD_W-1]}}, word};
   assign count_next = OVS_W'(decim_count_ff) + OVS_W'(1);
   assign group_done = count_next >= clamp_oversample(cfg.oversample);

   always_comb begin
      q_entry.clear_clips = req_clear_clips;
      q_entry.sum         = sum_next;
      if (req_restart) begin
         q_entry.kind = CMD_RESTART;
      end else if (group_done) begin
         q_entry.kind = CMD_SAMPLE;
      end else begin
         q_entry.kind = CMD_CLEAR;
      end
      q_push = accept && (req_restart || group_done || req_clear_clips);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_count_ff <= '0;
         decim_sum_ff   <= '0;
      end else if (accept) begin
         if (req_restart || group_done) begin
            decim_count_ff <= '0;
            decim_sum_ff   <= '0;
         end else begin
            decim_count_ff <= count_next[1:0];
            decim_sum_ff   <= sum_next;
         end
      end
   end

endmodule

FILE: sv/mdb_queue.sv
// ============================================================================
// mdb_queue
// short command queue between the front and the back end
// ============================================================================
module mdb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mdb_pkg::cmd_type      push_entry,
   input  logic                  pop,
   output mdb_pkg::cmd_type      head,
   output mdb_pkg::q_status_type status
);
   import mdb_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + QCNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("command popped from an empty queue");

endmodule

FILE: sv/mdb_back.sv
// ============================================================================
// mdb_back
// executes queued commands: divide, dc blocker, saturation, clip count,
// peak meter and the result register
// ============================================================================
module mdb_back (
   input  logic                              clock,
   input  logic                              reset,
   input  mdb_pkg::cfg_type                  cfg,
   input  mdb_pkg::q_status_type             q_status,
   input  mdb_pkg::cmd_type                  q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mdb_pkg::PCM_W-1:0]  rsp_pcm_sample,
   output logic                              rsp_clipped,
   output logic                              rsp_frame_end,
   output logic [mdb_pkg::LEVEL_W-1:0]       rsp_meter_level,
   output logic [mdb_pkg::CLIPS_W-1:0]       rsp_clip_total
);
   import mdb_pkg::*;

   localparam logic signed [Y_W-1:0] DCO_MAX = {1'b0, {(Y_W-1){1'b1}}};
   localparam logic signed [Y_W-1:0] DCO_MIN = {1'b1, {(Y_W-1){1'b0}}};
   localparam logic signed [Y_W-1:0] PCM_HI_Q = Y_W'(32767) <<< FRAC_W;
   localparam logic signed [Y_W-1:0] PCM_LO_Q = -(Y_W'(32768) <<< FRAC_W);
   localparam logic signed [PCM_W-1:0] PCM_MAX = {1'b0, {(PCM_W-1){1'b1}}};
   localparam logic signed [PCM_W-1:0] PCM_MIN = {1'b1, {(PCM_W-1){1'b0}}};

   back_state_type state_ff, state_in;
   logic           div_start, div_busy, out_load;
   logic [MAG_W-1:0] div_quotient, sum_mag;

   // architectural state
   logic signed [X_W-1:0] dc_last_input_ff;
   logic signed [Y_W-1:0] dc_last_output_ff;
   logic [POS_W-1:0]      frame_pos_ff;
   logic [PEAK_W-1:0]     frame_peak_ff;
   logic [LEVEL_W-1:0]    level_ff;
   logic [CLIPS_W-1:0]    clip_count_ff;

   // working registers
   logic                    sum_neg_ff;
   logic [PLO_W-1:0]        prod_lo_ff;
   logic signed [PHI_W-1:0] prod_hi_ff;
   logic signed [X_W-1:0]   x_ff;
   logic signed [D_W-1:0]   d_ff;
   logic signed [Y_W-1:0]   fb_ff;
   logic signed [PCM_W-1:0] pcm_ff;
   logic                    clip_ff, fend_ff;

   // result register
   logic                    rsp_valid_ff;
   logic signed [PCM_W-1:0] rsp_pcm_ff;
   logic                    rsp_clip_ff, rsp_fend_ff;
   logic [LEVEL_W-1:0]      rsp_level_ff;
   logic [CLIPS_W-1:0]      rsp_clips_ff;

   // combinational datapath
   logic signed [SUM_W-1:0] avg;
   logic signed [X_W-1:0]   x_in;
   logic signed [HI_W-1:0]  y1_hi;
   logic signed [POLE_W:0]  pole_s;
   logic signed [P_W-1:0]   prod_full;
   logic signed [Y_W:0]     y_wide;
   logic signed [Y_W-1:0]   y_sat;
   logic signed [Y_W-1:0]   y_trunc;
   logic signed [PCM_W-1:0] pcm_in;
   logic                    clip_in;
   logic [PEAK_W-1:0]       mag, peak_in;
   logic [SPF_W-1:0]        pos_next, frame_len;
   logic                    fend_in;
   logic [PCT_PROD_W-1:0]   pct_prod;
   logic [PCT_PROD_W-FULL_SHIFT-1:0] pct_coarse, pct;
   logic [FULL_SHIFT:0]     pct_rem;
   logic [LEVEL_W-1:0]      level_in;

   mdb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (clamp_oversample(cfg.oversample)),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign sum_mag = q_head.sum[SUM_W-1] ? MAG_W'(-q_head.sum) : MAG_W'(q_head.sum);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               if (q_head.kind == CMD_SAMPLE) begin
                  div_start = 1'b1;
                  state_in  = ST_MUL_HI;
               end
            end
         end
         ST_MUL_HI:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (!div_busy) state_in = ST_SUM;
         ST_SUM:      state_in = ST_SAT;
         ST_SAT:      state_in = ST_PCM;
         ST_PCM:      state_in = ST_METER;
         ST_METER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // scaled input, feedback product, sum and saturation
   assign avg    = sum_neg_ff ? -SUM_W'({1'b0, div_quotient}) : SUM_W'({1'b0, div_quotient});
   assign x_in   = {{(X_W-SUM_W){avg[SUM_W-1]}}, avg} <<< clamp_gain(cfg.gain_shift);
   assign y1_hi  = dc_last_output_ff[Y_W-1:LO_W];
   assign pole_s = {1'b0, cfg.dc_pole};
   assign prod_full = {prod_hi_ff, {LO_W{1'b0}}} + {{(P_W-PLO_W){1'b0}}, prod_lo_ff};
   assign y_wide = {{(Y_W+1-D_W){d_ff[D_W-1]}}, d_ff} + {fb_ff[Y_W-1], fb_ff};

   always_comb begin
      if (y_wide[Y_W] != y_wide[Y_W-1]) y_sat = y_wide[Y_W] ? DCO_MIN : DCO_MAX;
      else                              y_sat = y_wide[Y_W-1:0];
   end

   // saturation to int16 and truncation toward zero
   assign y_trunc = dc_last_output_ff
                  + (dc_last_output_ff[Y_W-1] ? Y_W'(16'hFFFF) : Y_W'(0));

   always_comb begin
      clip_in = 1'b1;
      if (dc_last_output_ff > PCM_HI_Q)      pcm_in = PCM_MAX;
      else if (dc_last_output_ff < PCM_LO_Q) pcm_in = PCM_MIN;
      else begin
         pcm_in  = y_trunc[FRAC_W +: PCM_W];
         clip_in = 1'b0;
      end
   end

   assign mag       = pcm_in[PCM_W-1] ? PEAK_W'(~pcm_in + 1'b1) : PEAK_W'(pcm_in);
   assign peak_in   = (mag > frame_peak_ff) ? mag : frame_peak_ff;
   assign pos_next  = SPF_W'(frame_pos_ff) + SPF_W'(1);
   assign frame_len = clamp_frame(cfg.samples_per_frame);
   assign fend_in   = pos_next >= frame_len;

   // peak * 100 / 32767: divide by 2^15, then one correction step
   assign pct_prod   = PCT_PROD_W'(frame_peak_ff) * PCT_PROD_W'(PCT_SCALE);
   assign pct_coarse = pct_prod[PCT_PROD_W-1:FULL_SHIFT];
   assign pct_rem    = (FULL_SHIFT+1)'(pct_prod[FULL_SHIFT-1:0])
                     + (FULL_SHIFT+1)'(pct_coarse);
   assign pct        = pct_coarse
                     + ((pct_rem >= (FULL_SHIFT+1)'(FULL_SCALE)) ? 1'b1 : 1'b0);

   always_comb begin
      if (pct > (PCT_PROD_W-FULL_SHIFT)'(level_ff))
         level_in = LEVEL_W'(pct);
      else if (level_ff > LEVEL_W'(LEVEL_RELEASE))
         level_in = level_ff - LEVEL_W'(LEVEL_RELEASE);
      else
         level_in = '0;
   end

   // architectural state and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         dc_last_input_ff  <= '0;
         dc_last_output_ff <= '0;
         frame_pos_ff      <= '0;
         frame_peak_ff     <= '0;
         level_ff          <= '0;
         clip_count_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (q_pop) begin
            if (q_head.clear_clips) clip_count_ff <= '0;
            if (q_head.kind == CMD_RESTART) begin
               dc_last_input_ff  <= '0;
               dc_last_output_ff <= '0;
               frame_pos_ff      <= '0;
               frame_peak_ff     <= '0;
            end
         end
         if (state_ff == ST_SUM) dc_last_input_ff  <= x_ff;
         if (state_ff == ST_SAT) dc_last_output_ff <= y_sat;
         if (state_ff == ST_PCM) begin
            frame_peak_ff <= peak_in;
            frame_pos_ff  <= fend_in ? '0 : pos_next[POS_W-1:0];
            if (clip_in) clip_count_ff <= clip_count_ff + CLIPS_W'(1);
         end
         if (out_load && fend_ff) begin
            level_ff      <= level_in;
            frame_peak_ff <= '0;
         end
         if (out_load)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      if (div_start) begin
         sum_neg_ff <= q_head.sum[SUM_W-1];
         prod_lo_ff <= PLO_W'(dc_last_output_ff[LO_W-1:0]) * PLO_W'(cfg.dc_pole);
      end
      if (state_ff == ST_MUL_HI) prod_hi_ff <= y1_hi * pole_s;
      if (state_ff == ST_DIV_WAIT && !div_busy) x_ff <= x_in;
      if (state_ff == ST_SUM) begin
         d_ff  <= {x_ff[X_W-1], x_ff} - {dc_last_input_ff[X_W-1], dc_last_input_ff};
         fb_ff <= prod_full[POLE_FRAC +: Y_W];
      end
      if (state_ff == ST_PCM) begin
         pcm_ff  <= pcm_in;
         clip_ff <= clip_in;
         fend_ff <= fend_in;
      end
      if (out_load) begin
         rsp_pcm_ff   <= pcm_ff;
         rsp_clip_ff  <= clip_ff;
         rsp_fend_ff  <= fend_ff;
         rsp_level_ff <= fend_ff ? level_in : level_ff;
         rsp_clips_ff <= clip_count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pcm_sample  = rsp_pcm_ff;
   assign rsp_clipped     = rsp_clip_ff;
   assign rsp_frame_end   = rsp_fend_ff;
   assign rsp_meter_level = rsp_level_ff;
   assign rsp_clip_total  = rsp_clips_ff;

   a_clip_is_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clip_ff |-> rsp_pcm_ff == PCM_MAX || rsp_pcm_ff == PCM_MIN)
      else $error("clipped beat without a full-scale sample");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(PCT_SCALE))
      else $error("meter level above full scale");

   a_quotient_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> !div_busy)
      else $error("blocker step started before the divide finished");

endmodule

FILE: sv/mic_decimate_dc_block_meter.sv
// ============================================================================
// mic_decimate_dc_block_meter
// mic slot select, boxcar decimation, dc blocker, int16 saturation with
// clip count, and a per-frame peak meter
// ============================================================================
// Each input beat is one I2S frame; only the slot chosen by mic_slot is kept.
// The front end takes one beat per clock while the command queue has room:
// beats that close no decimation group and carry no restart or clear produce
// nothing. A closing beat, a restart or a clip-counter clear becomes a command
// in a two-entry queue. The back end runs one sample command at a time: a
// shift when oversample is 1, 2 or 4 or the eight-bit-per-cycle divider when
// it is 3, alongside the two-part feedback multiply, then sum, saturate, pcm
// and meter steps. Restart and clear commands are taken in the idle state.
// The result register lets the back end finish its next command while a
// result beat waits on rsp_ready; only a second result stalls it.
// Configuration is taken on any cycle csr_wr_en is high and should only
// change while the block is idle.
module mic_decimate_dc_block_meter (
   input  logic                                   clock,
   input  logic                                   reset,
   // input frames
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [mdb_pkg::WORD_W-1:0]      req_slot0_word,
   input  logic signed [mdb_pkg::WORD_W-1:0]      req_slot1_word,
   input  logic                                   req_restart,
   input  logic                                   req_clear_clips,
   // output samples
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [mdb_pkg::PCM_W-1:0]       rsp_pcm_sample,
   output logic                                   rsp_clipped,
   output logic                                   rsp_frame_end,
   output logic [mdb_pkg::LEVEL_W-1:0]            rsp_meter_level,
   output logic [mdb_pkg::CLIPS_W-1:0]            rsp_clip_total,
   // configuration writes
   input  logic                                   csr_wr_en,
   input  logic [mdb_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [mdb_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import mdb_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         q_push, q_pop;
   cmd_type      q_entry, q_head;
   q_status_type q_status;

   // register file, writes beyond the map are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIC_SLOT:          cfg_in.mic_slot          = csr_wdata[0];
            CSR_OVERSAMPLE:        cfg_in.oversample        = csr_wdata[OVS_W-1:0];
            CSR_GAIN_SHIFT:        cfg_in.gain_shift        = csr_wdata[GAIN_W-1:0];
            CSR_DC_POLE:           cfg_in.dc_pole           = csr_wdata[POLE_W-1:0];
            CSR_SAMPLES_PER_FRAME: cfg_in.samples_per_frame = csr_wdata[SPF_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= CFG_RESET;
      else       cfg_ff <= cfg_in;
   end

   // front: slot select and group sums
   mdb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_slot0_word  (req_slot0_word),
      .req_slot1_word  (req_slot1_word),
      .req_restart     (req_restart),
      .req_clear_clips (req_clear_clips),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   // commands in order between the two halves
   mdb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // back: divide, blocker, saturation, meter, result register
   mdb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_status        (q_status),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pcm_sample  (rsp_pcm_sample),
      .rsp_clipped     (rsp_clipped),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_meter_level (rsp_meter_level),
      .rsp_clip_total  (rsp_clip_total)
   );

   a_ready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      req_ready == !q_status.full)
      else $error("input ready disagrees with queue space");

   a_push_needs_beat: assert property (@(posedge clock) disable iff (reset)
      q_push |-> req_valid && req_ready)
      else $error("command queued without an accepted beat");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_clip_total))
      else $error("result beat changed while stalled");

endmodule
